FILE: rtl/core/x64ptw_pkg.sv
`default_nettype none
package x64ptw_pkg;

	// Physical address width that the page table entries carry.
	localparam int unsigned PHYS_ADDR_BITS = 48;

	localparam int unsigned VA_W     = 48;
	localparam int unsigned ENTRY_W  = 64;
	localparam int unsigned ROOT_W   = 48;
	localparam int unsigned MEM_W    = 49;
	localparam int unsigned RADDR_W  = 49;
	localparam int unsigned PADDR_W  = 48;
	localparam int unsigned INDEX_W  = 9;
	localparam int unsigned LEVEL_W  = 2;

	localparam int unsigned PAGE_SHIFT  = 12;
	localparam int unsigned LARGE_SHIFT = 21;
	localparam int unsigned LARGE_BIT   = 7;

	// Wide enough for a base plus a page or large page size and for memory_bytes.
	localparam int unsigned CMP_W = (PHYS_ADDR_BITS >= MEM_W) ? PHYS_ADDR_BITS + 1 : MEM_W + 1;

	localparam logic [CMP_W-1:0] PAGE_BYTES  = CMP_W'(64'h1000);
	localparam logic [CMP_W-1:0] LARGE_BYTES = CMP_W'(64'h20_0000);

	localparam logic FUNC_TRANSLATE = 1'b0;
	localparam logic FUNC_RESPONSE  = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [LEVEL_W-1:0] LEVEL_PML4 = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_PDPT = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_PD   = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_PT   = 2'd3;

	// Register select is bit 3 of the byte address (registers are 8 bytes apart).
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 64;
	localparam logic REG_TABLE_ROOT   = 1'b0;
	localparam logic REG_MEMORY_BYTES = 1'b1;

	typedef struct packed {
		logic               func;
		logic [VA_W-1:0]    vaddr;
		logic [ENTRY_W-1:0] read_data;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic [RADDR_W-1:0] read_addr;
		logic [PADDR_W-1:0] phys_addr;
		logic               fault;
	} result_t;

	typedef struct packed {
		logic [ROOT_W-1:0] table_root;
		logic [MEM_W-1:0]  memory_bytes;
	} cfg_t;

	typedef struct packed {
		logic               busy;
		logic [LEVEL_W-1:0] level;
		logic [VA_W-1:0]    held_vaddr;
	} walk_t;

	function automatic logic [INDEX_W-1:0] level_index(input logic [VA_W-1:0] va,
		input logic [LEVEL_W-1:0] level);
		logic [INDEX_W-1:0] idx;
		case (level)
			LEVEL_PML4: idx = va[47:39];
			LEVEL_PDPT: idx = va[38:30];
			LEVEL_PD:   idx = va[29:21];
			LEVEL_PT:   idx = va[20:12];
			default:    idx = '0;
		endcase
		return idx;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/x64ptw_cfg_regs.sv
`default_nettype none
module x64ptw_cfg_regs
	import x64ptw_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic [ROOT_W-1:0] table_root_q;
	logic [MEM_W-1:0]  memory_bytes_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_root_q   <= '0;
			memory_bytes_q <= '0;
		end else if (wr_en) begin
			case (paddr[3])
				REG_TABLE_ROOT:   table_root_q   <= pwdata[ROOT_W-1:0];
				REG_MEMORY_BYTES: memory_bytes_q <= pwdata[MEM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_TABLE_ROOT:   prdata = APB_DATA_W'(table_root_q);
			REG_MEMORY_BYTES: prdata = APB_DATA_W'(memory_bytes_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.table_root   = table_root_q;
	assign cfg.memory_bytes = memory_bytes_q;

endmodule
`default_nettype wire

FILE: rtl/core/x64ptw_step.sv
`default_nettype none
module x64ptw_step
	import x64ptw_pkg::*;
(
	input  wire item_t   item,
	input  wire walk_t   walk,
	input  wire cfg_t    cfg,
	output logic    has_result,
	output result_t result,
	output walk_t   walk_next
);

	logic [PHYS_ADDR_BITS-1:0] base;
	logic [PHYS_ADDR_BITS-1:0] large_phys;
	logic [PHYS_ADDR_BITS-1:0] page_phys;
	logic [CMP_W-1:0]          mem_ext;
	logic [CMP_W-1:0]          base_end;
	logic [CMP_W-1:0]          large_end;
	logic [CMP_W-1:0]          next_read;
	logic [CMP_W-1:0]          root_read;
	logic [LEVEL_W-1:0]        level_inc;
	logic                      base_bad;
	logic                      large_bad;
	logic                      is_large;

	assign base       = {item.read_data[PHYS_ADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	assign large_phys = {item.read_data[PHYS_ADDR_BITS-1:LARGE_SHIFT],
		walk.held_vaddr[LARGE_SHIFT-1:0]};
	assign page_phys  = {base[PHYS_ADDR_BITS-1:PAGE_SHIFT], walk.held_vaddr[PAGE_SHIFT-1:0]};

	assign mem_ext   = CMP_W'(cfg.memory_bytes);
	assign base_end  = CMP_W'(base) + PAGE_BYTES;
	assign large_end = CMP_W'(large_phys) + LARGE_BYTES;
	assign base_bad  = (base == '0) || (base_end > mem_ext);
	assign large_bad = (large_phys == '0) || (large_end > mem_ext);
	assign is_large  = (walk.level == LEVEL_PD) && item.read_data[LARGE_BIT];

	assign level_inc = walk.level + LEVEL_W'(1);
	assign next_read = CMP_W'(base)
		+ CMP_W'({level_index(walk.held_vaddr, level_inc), 3'b000});
	assign root_read = CMP_W'(cfg.table_root)
		+ CMP_W'({level_index(item.vaddr, LEVEL_PML4), 3'b000});

	always_comb begin
		has_result       = 1'b0;
		result.kind      = KIND_READ;
		result.read_addr = '0;
		result.phys_addr = '0;
		result.fault     = 1'b0;
		walk_next        = walk;

		if (item.func == FUNC_TRANSLATE) begin
			if (!walk.busy) begin
				has_result           = 1'b1;
				result.read_addr     = RADDR_W'(root_read);
				walk_next.busy       = 1'b1;
				walk_next.level      = LEVEL_PML4;
				walk_next.held_vaddr = item.vaddr;
			end
		end else if (walk.busy) begin
			has_result = 1'b1;
			if (base_bad || is_large || walk.level == LEVEL_PT) begin
				// The walk ends here, as a fault or with a translation.
				result.kind     = KIND_DONE;
				walk_next.busy  = 1'b0;
				walk_next.level = LEVEL_PML4;
				if (base_bad || (is_large && large_bad)) begin
					result.fault = 1'b1;
				end else if (is_large) begin
					result.phys_addr = PADDR_W'(large_phys);
				end else begin
					result.phys_addr = PADDR_W'(page_phys);
				end
			end else begin
				result.read_addr = RADDR_W'(next_read);
				walk_next.level  = level_inc;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/x86_64_page_table_walker_unit.sv
// Four-level x86-64 page table walker.
// The item channel (item_valid, item_stall, item) carries translate requests
// (func = 0, vaddr) and memory read responses (func = 1, read_data). The result
// channel (result_valid, result_stall, result) returns either a memory read request
// (kind = 0, read_addr) or a finished translation (kind = 1, phys_addr, fault).
// A word is taken when its valid is high and its stall is low at a clock edge.
// Every accepted word is handled by a single combinational pass between the
// input register and the result register, so a new word is taken every cycle
// unless result_stall holds a pending result; results leave the result register.
// A request that arrives during a walk and a response that arrives outside a walk
// are consumed without a result.
// When result_stall holds a pending result, the word in the input register waits
// and item_stall rises; nothing is lost or repeated.
// table_root and memory_bytes are written over APB at byte addresses 0 and 8, by
// the user only while the walker is idle (unenforced); pready is always high.
// Asynchronous reset clears both registers, the walk state and all valid flags.
`default_nettype none
module x86_64_page_table_walker_unit
	import x64ptw_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	walk_t   walk_q;
	walk_t   walk_next;
	logic    has_result;
	result_t step_result;
	result_t result_q;
	logic    result_valid_q;
	logic    advance;
	logic    accept;

	x64ptw_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	x64ptw_step u_step (
		.item       (item_s1),
		.walk       (walk_q),
		.cfg        (cfg),
		.has_result (has_result),
		.result     (step_result),
		.walk_next  (walk_next)
	);

	// The staged word moves on whenever the result register is free or being drained.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (advance) begin
			walk_q <= walk_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire
